### rtl/bellman_ford_negative_cycle_detect_top_defines.svh
// assertion macros shared by the checker of the negative cycle detector
`ifndef BELLMAN_FORD_NEGATIVE_CYCLE_DETECT_TOP_DEFINES_SVH
`define BELLMAN_FORD_NEGATIVE_CYCLE_DETECT_TOP_DEFINES_SVH

// same-cycle implication
`define BFNC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfnc check failed");

// next-cycle implication
`define BFNC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfnc check failed");

`endif

### rtl/bfnc_pkg.sv
// types and constants of the negative cycle detector
`default_nettype none

package bfnc_pkg;

   localparam int VTX_W      = 10;
   localparam int WT_W       = 16;
   localparam int VCNT_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   // counter width for vertex and pass indexes, enough for 65536 vertices
   localparam int CNT_W      = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALL_SOURCES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VERTEX = 2'd2;

   localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = 11'd1;
   localparam logic              ALL_SOURCES_RST  = 1'b1;
   localparam logic [VTX_W-1:0]  START_VERTEX_RST = 10'd0;

   typedef struct packed {
      logic [VTX_W-1:0]        src;
      logic [VTX_W-1:0]        dst;
      logic signed [WT_W-1:0]  weight;
   } edge_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_CLEAR,
      ST_SEED,
      ST_EDGE_RD,
      ST_DIST_RD,
      ST_CALC,
      ST_UPDATE,
      ST_PASS_END,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic init_we;
      logic init_reach;
      logic rd_en;
      logic calc_en;
      logic upd_en;
   } dist_ctrl_type;

endpackage

`default_nettype wire

### rtl/bfnc_if.sv
// valid/ready channel interfaces for edge transfers and result transfers
`default_nettype none

interface bfnc_req_if;
   logic                                valid;
   logic                                ready;
   logic [bfnc_pkg::VTX_W-1:0]          src_vertex;
   logic [bfnc_pkg::VTX_W-1:0]          dst_vertex;
   logic signed [bfnc_pkg::WT_W-1:0]    weight;
   logic                                last_edge;

   modport source (output valid, src_vertex, dst_vertex, weight, last_edge, input ready);
   modport sink   (input valid, src_vertex, dst_vertex, weight, last_edge, output ready);
endinterface

interface bfnc_rsp_if;
   logic valid;
   logic ready;
   logic has_negative_cycle;

   modport source (output valid, has_negative_cycle, input ready);
   modport sink   (input valid, has_negative_cycle, output ready);
endinterface

`default_nettype wire

### rtl/bfnc_relax.sv
// vertex cost memory with the read, saturating add and write-back relaxation datapath
`default_nettype none

module bfnc_relax #(
   parameter int MAX_VERTICES = 1024,
   parameter int DIST_BITS    = 40,
   localparam int VW          = $clog2(MAX_VERTICES)
) (
   input  logic                             clock,
   input  bfnc_pkg::dist_ctrl_type          ctrl,
   input  logic [VW-1:0]                    init_addr,
   input  logic [VW-1:0]                    src_idx,
   input  logic [VW-1:0]                    dst_idx,
   input  logic                             edge_ok,
   input  logic signed [bfnc_pkg::WT_W-1:0] weight,
   output logic                             relaxed
);

   localparam int EXT_W = DIST_BITS + 1 - bfnc_pkg::WT_W;
   localparam logic [DIST_BITS-1:0] COST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
   localparam logic [DIST_BITS-1:0] COST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

   typedef struct packed {
      logic                  reach;
      logic [DIST_BITS-1:0]  cost;
   } cost_entry_type;

   cost_entry_type        mem [MAX_VERTICES];
   cost_entry_type        qa_ff;
   cost_entry_type        qb_ff;
   logic [VW-1:0]         dst_ff;
   logic                  ok_ff;
   logic                  go_ff;
   logic                  go_in;
   logic [DIST_BITS-1:0]  cand_ff;
   logic [DIST_BITS-1:0]  cand_in;
   logic [DIST_BITS:0]    sum;

   // candidate = cost[u] + w, clamped to the cost range
   always_comb begin
      sum = {qa_ff.cost[DIST_BITS-1], qa_ff.cost}
          + {{EXT_W{weight[bfnc_pkg::WT_W-1]}}, weight};
      if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
         cand_in = sum[DIST_BITS] ? COST_MIN : COST_MAX;
      end else begin
         cand_in = sum[DIST_BITS-1:0];
      end
      go_in = ok_ff && qa_ff.reach;
   end

   assign relaxed = ctrl.upd_en && go_ff
                    && (!qb_ff.reach || ($signed(qb_ff.cost) > $signed(cand_ff)));

   always_ff @(posedge clock) begin
      if (ctrl.init_we) begin
         mem[init_addr] <= '{reach: ctrl.init_reach, cost: '0};
      end else if (relaxed) begin
         mem[dst_ff] <= '{reach: 1'b1, cost: cand_ff};
      end
      if (ctrl.rd_en) begin
         qa_ff  <= mem[src_idx];
         qb_ff  <= mem[dst_idx];
         dst_ff <= dst_idx;
         ok_ff  <= edge_ok;
      end
      if (ctrl.calc_en) begin
         cand_ff <= cand_in;
         go_ff   <= go_in;
      end
   end

endmodule

`default_nettype wire

### rtl/bellman_ford_negative_cycle_detect_top.sv
// negative cycle detector: edge store, run sequencer and configuration registers
//
//   channel | dir | transfer                       | payload
//   --------+-----+--------------------------------+---------------------------------------
//   req_if  | in  | one edge per transfer           | src_vertex, dst_vertex, weight, last_edge
//   rsp_if  | out | one flag per graph              | has_negative_cycle
//   csr_*   | in  | register write, no handshake    | csr_index, csr_wdata
//
// edges load one per cycle while idle; the transfer with last_edge set starts a run and
// req_if.ready stays low until the run ends
// per start vertex: a check state, a clear sweep over nv cost entries, a seed state, then up to
// nv passes of edge read, cost read, add and compare/write-back per edge plus one pass check
// with all_sources set up to nv starts are tried; the finish state loads the output register
// reset is synchronous, no clearing pass; a result waiting on rsp_if.ready stalls only the finish
`default_nettype none

module bellman_ford_negative_cycle_detect_top #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096,
   parameter int DIST_BITS    = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   bfnc_req_if.sink                            req_if,
   bfnc_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [bfnc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfnc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int CW  = bfnc_pkg::CNT_W;
   localparam logic [CW-1:0]  MAXV = CW'(MAX_VERTICES);
   localparam logic [ECW-1:0] MAXE = ECW'(MAX_EDGES);

   // configuration registers
   logic [bfnc_pkg::VCNT_W-1:0] vertex_count_ff;
   logic                        all_sources_ff;
   logic [bfnc_pkg::VTX_W-1:0]  start_vertex_ff;

   // sequencer state
   bfnc_pkg::state_type state_ff, state_in;
   logic [ECW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0]  nv_ff, nv_in;
   logic           all_ff, all_in;
   logic [CW-1:0]  src_ff, src_in;       // current start vertex
   logic [CW-1:0]  idx_ff, idx_in;       // clear sweep index
   logic [CW-1:0]  pass_ff, pass_in;
   logic [ECW-1:0] k_ff, k_in;           // edge index within a pass
   logic           changed_ff, changed_in;
   logic           hit_ff, hit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_flag_ff, rsp_flag_in;

   bfnc_pkg::edge_type edge_mem [MAX_EDGES];
   bfnc_pkg::edge_type edge_q_ff;

   logic                    req_fire;
   logic                    store_we;
   logic                    rsp_load;
   logic                    last_k;
   logic                    relaxed;
   logic [CW-1:0]           u_cw;
   logic [CW-1:0]           v_cw;
   logic                    edge_ok;
   logic [VW-1:0]           init_addr;
   bfnc_pkg::dist_ctrl_type dctrl;

   assign req_fire = req_if.valid && req_if.ready;
   assign store_we = req_fire && (edge_count_ff != MAXE);
   assign rsp_load = (state_ff == bfnc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);
   assign last_k   = (ECW'(k_ff + ECW'(1)) == edge_count_ff);

   assign u_cw    = CW'(edge_q_ff.src);
   assign v_cw    = CW'(edge_q_ff.dst);
   assign edge_ok = (u_cw < nv_ff) && (v_cw < nv_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= bfnc_pkg::VERTEX_COUNT_RST;
         all_sources_ff  <= bfnc_pkg::ALL_SOURCES_RST;
         start_vertex_ff <= bfnc_pkg::START_VERTEX_RST;
      end else if (csr_we) begin
         case (csr_index)
            bfnc_pkg::CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[bfnc_pkg::VCNT_W-1:0];
            bfnc_pkg::CSR_ALL_SOURCES:  all_sources_ff  <= csr_wdata[0];
            bfnc_pkg::CSR_START_VERTEX: start_vertex_ff <= csr_wdata[bfnc_pkg::VTX_W-1:0];
            default: ;
         endcase
      end
   end

   // edge store: written on load, read once per relaxation step
   always_ff @(posedge clock) begin
      if (store_we) begin
         edge_mem[edge_count_ff[EAW-1:0]] <= '{src:    req_if.src_vertex,
                                               dst:    req_if.dst_vertex,
                                               weight: req_if.weight};
      end
      if (state_ff == bfnc_pkg::ST_EDGE_RD) begin
         edge_q_ff <= edge_mem[k_ff[EAW-1:0]];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfnc_pkg::ST_IDLE: begin
            if (req_fire && req_if.last_edge) state_in = bfnc_pkg::ST_START;
         end
         bfnc_pkg::ST_START: begin
            // no vertices, or a fixed start outside the graph: nothing reached
            if ((nv_ff == '0) || (src_ff >= nv_ff)) state_in = bfnc_pkg::ST_FINISH;
            else                                   state_in = bfnc_pkg::ST_CLEAR;
         end
         bfnc_pkg::ST_CLEAR: begin
            if (idx_ff == CW'(nv_ff - CW'(1))) state_in = bfnc_pkg::ST_SEED;
         end
         bfnc_pkg::ST_SEED:    state_in = bfnc_pkg::ST_EDGE_RD;
         bfnc_pkg::ST_EDGE_RD: state_in = bfnc_pkg::ST_DIST_RD;
         bfnc_pkg::ST_DIST_RD: state_in = bfnc_pkg::ST_CALC;
         bfnc_pkg::ST_CALC:    state_in = bfnc_pkg::ST_UPDATE;
         bfnc_pkg::ST_UPDATE: begin
            if (last_k) state_in = bfnc_pkg::ST_PASS_END;
            else        state_in = bfnc_pkg::ST_EDGE_RD;
         end
         bfnc_pkg::ST_PASS_END: begin
            if (!changed_ff) begin
               // settled early: no cycle from this start
               if (all_ff && (CW'(src_ff + CW'(1)) < nv_ff)) state_in = bfnc_pkg::ST_START;
               else                                          state_in = bfnc_pkg::ST_FINISH;
            end else if (pass_ff == CW'(nv_ff - CW'(1))) begin
               state_in = bfnc_pkg::ST_FINISH;
            end else begin
               state_in = bfnc_pkg::ST_EDGE_RD;
            end
         end
         bfnc_pkg::ST_FINISH: begin
            if (rsp_load) state_in = bfnc_pkg::ST_IDLE;
         end
         default: state_in = bfnc_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_if.ready     = (state_ff == bfnc_pkg::ST_IDLE);
      dctrl.init_we    = (state_ff == bfnc_pkg::ST_CLEAR) || (state_ff == bfnc_pkg::ST_SEED);
      dctrl.init_reach = (state_ff == bfnc_pkg::ST_SEED);
      dctrl.rd_en      = (state_ff == bfnc_pkg::ST_DIST_RD);
      dctrl.calc_en    = (state_ff == bfnc_pkg::ST_CALC);
      dctrl.upd_en     = (state_ff == bfnc_pkg::ST_UPDATE);
      if (state_ff == bfnc_pkg::ST_CLEAR) init_addr = idx_ff[VW-1:0];
      else                                init_addr = src_ff[VW-1:0];
   end

   // counters and result
   always_comb begin
      edge_count_in = edge_count_ff;
      nv_in         = nv_ff;
      all_in        = all_ff;
      src_in        = src_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      k_in          = k_ff;
      changed_in    = changed_ff;
      hit_in        = hit_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      if (store_we) edge_count_in = ECW'(edge_count_ff + ECW'(1));

      case (state_ff)
         bfnc_pkg::ST_IDLE: begin
            if (req_fire && req_if.last_edge) begin
               // vertex count above the memory size is clipped
               nv_in  = (CW'(vertex_count_ff) > MAXV) ? MAXV : CW'(vertex_count_ff);
               all_in = all_sources_ff;
               src_in = all_sources_ff ? '0 : CW'(start_vertex_ff);
               hit_in = 1'b0;
            end
         end
         bfnc_pkg::ST_START: idx_in = '0;
         bfnc_pkg::ST_CLEAR: idx_in = CW'(idx_ff + CW'(1));
         bfnc_pkg::ST_SEED: begin
            pass_in    = '0;
            k_in       = '0;
            changed_in = 1'b0;
         end
         bfnc_pkg::ST_UPDATE: begin
            if (relaxed) changed_in = 1'b1;
            if (!last_k) k_in = ECW'(k_ff + ECW'(1));
         end
         bfnc_pkg::ST_PASS_END: begin
            if (!changed_ff) begin
               src_in = CW'(src_ff + CW'(1));
            end else if (pass_ff == CW'(nv_ff - CW'(1))) begin
               hit_in = 1'b1;
            end else begin
               pass_in    = CW'(pass_ff + CW'(1));
               k_in       = '0;
               changed_in = 1'b0;
            end
         end
         bfnc_pkg::ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_flag_in   = hit_ff;
               edge_count_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfnc_pkg::ST_IDLE;
         edge_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nv_ff       <= nv_in;
      all_ff      <= all_in;
      src_ff      <= src_in;
      idx_ff      <= idx_in;
      pass_ff     <= pass_in;
      k_ff        <= k_in;
      changed_ff  <= changed_in;
      hit_ff      <= hit_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.has_negative_cycle = rsp_flag_ff;

   // cost memory and relaxation datapath
   bfnc_relax #(
      .MAX_VERTICES (MAX_VERTICES),
      .DIST_BITS    (DIST_BITS)
   ) u_relax (
      .clock     (clock),
      .ctrl      (dctrl),
      .init_addr (init_addr),
      .src_idx   (u_cw[VW-1:0]),
      .dst_idx   (v_cw[VW-1:0]),
      .edge_ok   (edge_ok),
      .weight    (edge_q_ff.weight),
      .relaxed   (relaxed)
   );

endmodule

`default_nettype wire

### rtl/bfnc_checker.sv
// port-level checker of the negative cycle detector and its bind
`default_nettype none

`include "bellman_ford_negative_cycle_detect_top_defines.svh"

module bfnc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_edge,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_flag
);

   // a stalled result stays offered
   `BFNC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled result keeps its flag
   `BFNC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_flag))

   // the last edge starts a run, so loading stops right after it
   `BFNC_ASSERT_NEXT(a_run_blocks, clock, reset, req_valid && req_ready && req_last_edge, !req_ready)

   // a new result only comes out of a run, never while edges are being taken
   `BFNC_ASSERT_IMPL(a_rsp_from_run, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind bellman_ford_negative_cycle_detect_top bfnc_checker u_bfnc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_last_edge (req_if.last_edge),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_flag      (rsp_if.has_negative_cycle)
);

`default_nettype wire

### test/tb_bellman_ford_negative_cycle_detect_top.sv
// self-checking testbench for the negative cycle detector: edge loading, runs and flag results
`default_nettype none

module tb_bellman_ford_negative_cycle_detect_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     VERTEX_CAP    = 1024;
   localparam int     EDGE_CAP      = 4096;
   localparam int     COST_BITS     = 40;
   localparam longint COST_MAX      = (longint'(1) << (COST_BITS - 1)) - 1;
   localparam longint COST_MIN      = -COST_MAX - 1;
   localparam int     VTX_BITS      = bfnc_pkg::VTX_W;
   localparam int     WT_BITS       = bfnc_pkg::WT_W;
   localparam int     VCNT_BITS     = bfnc_pkg::VCNT_W;
   localparam int     CSR_BITS      = bfnc_pkg::CSR_DATA_W;
   // longest idle stretch on either channel
   localparam int     LONG_GAP      = 40;
   // idle cycles after the last flag before touching the registers
   localparam int     SETTLE_CYCLES = 8;
   localparam int     DRAIN_CYCLES  = 64;
   localparam int     RANDOM_EDGES  = 1300;

   // directed plan: config rows carry vertex_count, all_sources, start_vertex in x0..x2,
   // edge rows carry src, dst, weight; flag is the typed-in result where known is set
   typedef enum logic {ROW_CONFIG, ROW_EDGE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           x0;
      int           x1;
      int           x2;
      bit           last;
      bit           known;
      bit           flag;
   } plan_row_type;

   localparam int PLAN_ROWS = 29;

   plan_row_type plan [PLAN_ROWS] = '{
      // reset settings: one vertex, every start tried
      '{ROW_EDGE,   0,    0,     -1, 1, 1, 1},   // negative self loop on the only vertex
      '{ROW_EDGE,   0,    0,      0, 1, 1, 0},   // zero self loop, nothing improves
      // no vertices at all
      '{ROW_CONFIG, 0,    1,      0, 0, 0, 0},
      '{ROW_EDGE,   0,    0, -32768, 1, 1, 0},
      // fixed start, triangle with a negative sum
      '{ROW_CONFIG, 3,    0,      0, 0, 0, 0},
      '{ROW_EDGE,   0,    1,      5, 0, 0, 0},
      '{ROW_EDGE,   1,    2,     -3, 0, 0, 0},
      '{ROW_EDGE,   2,    0,     -4, 1, 1, 1},
      // weight extremes summing to minus one
      '{ROW_EDGE,   0,    1,  32767, 0, 0, 0},
      '{ROW_EDGE,   1,    0, -32768, 1, 1, 1},
      // start vertex outside the graph reaches nothing
      '{ROW_CONFIG, 3,    0,   1023, 0, 0, 0},
      '{ROW_EDGE,   0,    1,     -5, 0, 0, 0},
      '{ROW_EDGE,   1,    0,     -5, 1, 1, 0},
      // edges leaving the graph are skipped
      '{ROW_CONFIG, 3,    0,      2, 0, 0, 0},
      '{ROW_EDGE,   1023, 1023,  -1, 0, 0, 0},
      '{ROW_EDGE,   2,    1023,  -7, 0, 0, 0},
      '{ROW_EDGE,   2,    2,      1, 1, 1, 0},
      // largest graph, cycle through the top vertex
      '{ROW_CONFIG, 1024, 0,   1023, 0, 0, 0},
      '{ROW_EDGE,   1023, 0,     -2, 0, 0, 0},
      '{ROW_EDGE,   0,    1023,   1, 1, 1, 1},
      // vertex count above the limit acts as the limit
      '{ROW_CONFIG, 2047, 0,      0, 0, 0, 0},
      '{ROW_EDGE,   0,    1023,  -1, 0, 0, 0},
      '{ROW_EDGE,   1023, 0,      0, 1, 1, 1},
      // every start tried: no hit, then a cycle first found from start vertex 2
      '{ROW_CONFIG, 4,    1,      0, 0, 0, 0},
      '{ROW_EDGE,   2,    3,     -1, 0, 0, 0},
      '{ROW_EDGE,   3,    2,      2, 0, 0, 0},
      '{ROW_EDGE,   3,    3,      7, 1, 1, 0},
      '{ROW_EDGE,   3,    2,     -1, 0, 0, 0},
      '{ROW_EDGE,   2,    3,      0, 1, 1, 1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_we;
   logic [bfnc_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [bfnc_pkg::CSR_DATA_W-1:0]     csr_wdata;

   bfnc_req_if req_bus ();
   bfnc_rsp_if rsp_bus ();

   bellman_ford_negative_cycle_detect_top #(
      .MAX_VERTICES (VERTEX_CAP),
      .MAX_EDGES    (EDGE_CAP),
      .DIST_BITS    (COST_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // own model of the detector: edge store, path costs, reached marks and register copies
   // ---------------------------------------------------------------------------------------
   bfnc_pkg::edge_type          stored_edges [EDGE_CAP];
   int                          stored_count = 0;
   longint                      path_cost [VERTEX_CAP];
   bit                          reached [VERTEX_CAP];
   logic [VCNT_BITS-1:0]        cfg_vertex_count = bfnc_pkg::VERTEX_COUNT_RST;
   bit                          cfg_all_sources  = bfnc_pkg::ALL_SOURCES_RST;
   logic [VTX_BITS-1:0]         cfg_start_vertex = bfnc_pkg::START_VERTEX_RST;

   // flags still owed by the block, oldest first
   bit     expected_flags [$];
   int     error_count     = 0;
   int     edges_sent      = 0;
   int     flags_checked   = 0;
   int     cycles_found    = 0;
   int     configs_applied = 0;
   // worst-case cycles the work so far may take; the watchdog allows a multiple of it
   longint cycle_budget    = 4000;
   longint cycle_count     = 0;
   // phases with no idling on the edge side or the result side
   bit     req_steady      = 1'b0;
   bit     rsp_steady      = 1'b0;

   function automatic longint add_clamped(input longint cost, input int weight);
      longint sum;
      sum = cost + weight;
      if (sum > COST_MAX)
         return COST_MAX;
      if (sum < COST_MIN)
         return COST_MIN;
      return sum;
   endfunction

   // one sweep over the stored edges in load order; tells whether anything improved
   function automatic bit relax_all(input int nv);
      bit     changed;
      int     k;
      int     u;
      int     v;
      longint cand;
      changed = 1'b0;
      for (k = 0; k < stored_count; k++) begin
         u = stored_edges[k].src;
         v = stored_edges[k].dst;
         if (u < nv && v < nv && reached[u]) begin
            cand = add_clamped(path_cost[u], stored_edges[k].weight);
            if (!reached[v] || path_cost[v] > cand) begin
               path_cost[v] = cand;
               reached[v]   = 1'b1;
               changed      = 1'b1;
            end
         end
      end
      return changed;
   endfunction

   // nv-1 sweeps then one more; a quiet sweep ends the search early
   function automatic bit cycle_from(input int start, input int nv);
      int i;
      for (i = 0; i < nv; i++) begin
         reached[i]   = 1'b0;
         path_cost[i] = 0;
      end
      if (start >= nv)
         return 1'b0;
      reached[start] = 1'b1;
      for (i = 0; i + 1 < nv; i++) begin
         if (!relax_all(nv))
            return 1'b0;
      end
      return relax_all(nv);
   endfunction

   function automatic void store_edge_and_detect(input bfnc_pkg::edge_type e, input bit last,
                                                 output bit produced, output bit flag);
      int nv;
      int starts;
      int s;
      produced = last;
      flag     = 1'b0;
      // a full store drops the edge, but a last edge still starts the run
      if (stored_count < EDGE_CAP) begin
         stored_edges[stored_count] = e;
         stored_count++;
      end
      if (!last)
         return;
      nv     = (cfg_vertex_count > VERTEX_CAP) ? VERTEX_CAP : int'(cfg_vertex_count);
      starts = cfg_all_sources ? nv : 1;
      // clear, seed and every pass for every start, plus the longest result stall
      cycle_budget += longint'(starts) * (nv + 2 + longint'(nv) * (4 * stored_count + 2))
                      + LONG_GAP + 4;
      if (cfg_all_sources) begin
         for (s = 0; s < nv && !flag; s++)
            flag = cycle_from(s, nv);
      end else begin
         flag = cycle_from(int'(cfg_start_vertex), nv);
      end
      // the next edge begins a new graph
      stored_count = 0;
   endfunction

   // mostly back-to-back, sometimes a short pause, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, LONG_GAP);
   endfunction

   // ---------------------------------------------------------------------------------------
   // edge side: one transfer per call, valid stays up so the next call can follow directly
   // ---------------------------------------------------------------------------------------
   task automatic send_edge(input bfnc_pkg::edge_type e, input bit last, input bit known,
                            input bit known_flag);
      int gap;
      bit produced;
      bit flag;
      gap = req_steady ? 0 : pick_gap();
      cycle_budget += LONG_GAP + 4;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.src_vertex <= e.src;
      req_bus.dst_vertex <= e.dst;
      req_bus.weight     <= e.weight;
      req_bus.last_edge  <= last;
      // wait for the edge where valid and ready meet
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      edges_sent++;
      store_edge_and_detect(e, last, produced, flag);
      if (produced)
         expected_flags = {expected_flags, (known ? known_flag : flag)};
   endtask

   // register writes only while the block is idle: every flag back, then a short settle
   task automatic apply_config(input int vcount, input int all_src, input int start);
      req_bus.valid <= 1'b0;
      while (expected_flags.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= bfnc_pkg::CSR_VERTEX_COUNT;
      csr_wdata <= CSR_BITS'(vcount);
      @(posedge clock);
      csr_index <= bfnc_pkg::CSR_ALL_SOURCES;
      csr_wdata <= CSR_BITS'(all_src);
      @(posedge clock);
      csr_index <= bfnc_pkg::CSR_START_VERTEX;
      csr_wdata <= CSR_BITS'(start);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_vertex_count = VCNT_BITS'(vcount);
      cfg_all_sources  = all_src[0];
      cfg_start_vertex = VTX_BITS'(start);
      configs_applied++;
      cycle_budget += SETTLE_CYCLES + 8;
   endtask

   // ---------------------------------------------------------------------------------------
   // result side: random back-pressure, every flag compared with the oldest expectation
   // ---------------------------------------------------------------------------------------
   initial begin : flag_sink
      int stall;
      bit want;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_flags.size() == 0) begin
               error_count++;
               $display("%0t: flag transfer with nothing expected, got %0b",
                        $time, rsp_bus.has_negative_cycle);
            end else begin
               want = expected_flags.pop_front();
               flags_checked++;
               if (want)
                  cycles_found++;
               if (rsp_bus.has_negative_cycle !== want) begin
                  error_count++;
                  $display("%0t: has_negative_cycle mismatch, expected %0b got %0b",
                           $time, want, rsp_bus.has_negative_cycle);
               end
            end
         end
         // one assignment to ready per edge
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 3) == 0)
               stall = pick_gap();
         end
      end
   end

   // watchdog: the limit grows with the work handed to the block
   initial begin : watchdog
      while (cycle_count <= 4 * cycle_budget + 10000) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d flags still owed",
               $time, cycle_count, expected_flags.size());
      $display("bellman_ford_negative_cycle_detect_top regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus: directed plan, then random graphs under random settings
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int                 i;
      int                 r;
      int                 vcount;
      int                 span;
      int                 edges_in_graph;
      int                 random_sent;
      bfnc_pkg::edge_type e;

      req_bus.valid      <= 1'b0;
      req_bus.src_vertex <= '0;
      req_bus.dst_vertex <= '0;
      req_bus.weight     <= '0;
      req_bus.last_edge  <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= bfnc_pkg::CSR_VERTEX_COUNT;
      csr_wdata          <= '0;
      random_sent        = 0;

      // synchronous reset held at the start, never again
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan
      for (i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_CONFIG) begin
            apply_config(plan[i].x0, plan[i].x1, plan[i].x2);
         end else begin
            e.src    = VTX_BITS'(plan[i].x0);
            e.dst    = VTX_BITS'(plan[i].x1);
            e.weight = WT_BITS'(plan[i].x2);
            send_edge(e, plan[i].last, plan[i].known, plan[i].flag);
         end
      end

      // random phases: a setting, a few graphs, mostly in-range edges with small weights
      while (random_sent < RANDOM_EDGES) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            vcount = 0;
         else if (r < 12)
            vcount = 1;
         else if (r < 92)
            vcount = $urandom_range(2, 8);
         else
            vcount = $urandom_range(9, 16);
         apply_config(vcount, $urandom_range(0, 1),
                      ($urandom_range(0, 6) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, (vcount > 0) ? vcount - 1 : 0));
         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         span = (vcount > 0) ? vcount : 4;
         repeat ($urandom_range(3, 8)) begin
            edges_in_graph = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
            for (i = 0; i < edges_in_graph; i++) begin
               // a tenth of the vertex fields are noise across the whole range
               e.src = ($urandom_range(0, 9) == 0) ? VTX_BITS'($urandom)
                                                   : VTX_BITS'($urandom_range(0, span - 1));
               e.dst = ($urandom_range(0, 9) == 0) ? VTX_BITS'($urandom)
                                                   : VTX_BITS'($urandom_range(0, span - 1));
               r = $urandom_range(0, 99);
               if (r < 50)
                  e.weight = WT_BITS'(int'($urandom_range(0, 24)) - 8);
               else if (r < 85)
                  e.weight = WT_BITS'(int'($urandom_range(0, 600)) - 200);
               else
                  e.weight = WT_BITS'($urandom);
               send_edge(e, i == edges_in_graph - 1, 1'b0, 1'b0);
               random_sent++;
            end
         end
      end

      // drain: every flag back, then a quiet stretch to catch stray transfers
      req_bus.valid <= 1'b0;
      while (expected_flags.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d edge transfers under %0d register settings, directed and random",
               edges_sent, configs_applied);
      $display("checked %0d flags, %0d of them negative cycles, %0d errors",
               flags_checked, cycles_found, error_count);
      if (error_count == 0)
         $display("bellman_ford_negative_cycle_detect_top regression: pass");
      else
         $display("bellman_ford_negative_cycle_detect_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
